### rtl/core/wgs_pkg.sv
// ----------------------------------------------------------------------------
// wgs_pkg
// Shared constants, codes and helpers for the wave grid stencil block.
// ----------------------------------------------------------------------------
package wgs_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int PADDR_W    = 5;
    localparam int ACC_W      = 50;

    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_DISTURB = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;

    localparam logic [2:0] REG_NUM_ROWS  = 3'd0;
    localparam logic [2:0] REG_NUM_COLS  = 3'd1;
    localparam logic [2:0] REG_COEF_PREV = 3'd2;
    localparam logic [2:0] REG_COEF_CURR = 3'd3;
    localparam logic [2:0] REG_COEF_NBR  = 3'd4;
    localparam logic [2:0] REG_STEP_PER  = 3'd5;

    typedef struct packed {
        logic clr;   // zero the accumulator
        logic mul;   // register coef * value
        logic acc;   // add the rounded product
    } t_mac_ctl;

    function automatic logic signed [31:0] f_sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] res;
        if (v > $signed({{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF})) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000})) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

### rtl/core/wgs_ram.sv
// ----------------------------------------------------------------------------
// wgs_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wgs_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

### rtl/core/wgs_mac.sv
// ----------------------------------------------------------------------------
// wgs_mac
// Shared multiply-accumulate unit: Q16.16 product, round half up, accumulate.
// ----------------------------------------------------------------------------
module wgs_mac (
    input  logic                i_clk,
    input  wgs_pkg::t_mac_ctl   i_ctl,
    input  logic signed [31:0]  i_coef,
    input  logic signed [31:0]  i_val,
    output logic signed [31:0]  o_sat
);
    import wgs_pkg::*;

    logic signed [63:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [63:0]      rnd_full;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] n_acc;

    // floor((p + 2^15) / 2^16)
    assign rnd_full = (r_prod + 64'sd32768) >>> 16;
    assign rnd      = rnd_full[ACC_W-1:0];

    always_comb begin
        n_acc = i_ctl.clr ? '0 : r_acc;
        if (i_ctl.acc) begin
            n_acc = n_acc + rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_coef * i_val;
        end
        r_acc <= n_acc;
    end

    assign o_sat = f_sat32(r_acc);
endmodule

### rtl/core/wave_grid_stencil_step.sv
// ----------------------------------------------------------------------------
// wave_grid_stencil_step
// 2-D wave equation finite-difference step over two Q16.16 height grids.
// ----------------------------------------------------------------------------
// One word in, one result word out. After reset the block zeroes both grid
// RAMs (stall held high), then accepts words one at a time. A disturb makes
// five read-modify-write passes over the single read port of the current
// grid. A tick that steps sweeps every interior point: four reads of the
// current-grid RAM port feed the neighbor sum and a fifth reads the point
// itself, then the one shared 32x32 multiplier forms the three products in
// turn. The result waits in an output register; the next word is taken once
// the result is handed over or placed.
// ----------------------------------------------------------------------------
module wave_grid_stencil_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_func,
    input  logic [31:0]                 i_elapsed,
    input  logic [5:0]                  i_row,
    input  logic [5:0]                  i_col,
    input  logic signed [31:0]          i_magnitude,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_height,
    output logic                        o_stepped,
    output logic                        o_error,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wgs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import wgs_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_RQ    = 3'd3;
    localparam logic [2:0] ST_DRD   = 3'd4;
    localparam logic [2:0] ST_DWR   = 3'd5;
    localparam logic [2:0] ST_SWEEP = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    localparam logic [6:0] ROWS_LIM = 7'(MAX_ROWS);
    localparam logic [6:0] COLS_LIM = 7'(MAX_COLS);

    // sweep phases of one stencil point
    localparam logic [3:0] PH_LAST = 4'd9;

    logic [2:0]         r_state;
    logic [ADDR_W-1:0]  r_clr_cnt;
    logic               r_cur_b;
    logic [31:0]        r_accum;
    logic [6:0]         r_num_rows;
    logic [6:0]         r_num_cols;
    logic signed [31:0] r_k1;
    logic signed [31:0] r_k2;
    logic signed [31:0] r_k3;
    logic [31:0]        r_step_per;

    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic signed [31:0] r_mag;
    logic [2:0]         r_k;
    logic [3:0]         r_ph;
    logic signed [33:0] r_nsum;
    logic signed [31:0] r_pval;
    logic signed [31:0] r_cval;

    logic signed [31:0] r_res_h;
    logic               r_res_s;
    logic               r_res_e;
    logic               r_o_valid;
    logic signed [31:0] r_o_height;
    logic               r_o_stepped;
    logic               r_o_error;

    logic [6:0]         rows_u;
    logic [6:0]         cols_u;
    logic               accept;
    logic [32:0]        tsum;
    logic [31:0]        tacc;
    logic               step_go;
    logic               sweep_go;
    logic               disturb_ok;
    logic               read_ok;
    logic               out_load;
    logic               wr_en;
    logic               wr_cur;
    logic [ADDR_W-1:0]  wr_addr;
    logic signed [31:0] wr_data;
    logic [ADDR_W-1:0]  cur_ra;
    logic [ADDR_W-1:0]  prv_ra;
    logic [ROW_W-1:0]   d_row;
    logic [COL_W-1:0]   d_col;
    logic signed [31:0] amt;
    logic               tgt_b;
    logic               we_a;
    logic               we_b;
    logic [ADDR_W-1:0]  wa;
    logic [31:0]        wd;
    logic [31:0]        q_a;
    logic [31:0]        q_b;
    logic signed [31:0] cur_q;
    logic signed [31:0] prv_q;
    t_mac_ctl           mac_ctl;
    logic signed [31:0] mac_coef;
    logic signed [31:0] mac_val;
    logic signed [31:0] mac_out;
    logic signed [31:0] nsat;
    logic [2:0]         cfg_idx;

    assign rows_u = (r_num_rows > ROWS_LIM) ? ROWS_LIM : r_num_rows;
    assign cols_u = (r_num_cols > COLS_LIM) ? COLS_LIM : r_num_cols;
    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;

    // saturating time accumulation
    assign tsum = {1'b0, r_accum} + {1'b0, i_elapsed};
    assign tacc = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];

    // decode of the offered word
    assign step_go    = (i_func == FUNC_TICK) && (tacc >= r_step_per);
    assign sweep_go   = step_go && (rows_u >= 7'd3) && (cols_u >= 7'd3);
    assign disturb_ok = i_row >= ROW_W'(2) && ({1'b0, i_row} + 7'd2) < rows_u
                        && i_col >= COL_W'(2) && ({1'b0, i_col} + 7'd2) < cols_u;
    assign read_ok    = ({1'b0, i_row} < rows_u) && ({1'b0, i_col} < cols_u);

    // place the result once the output register is free or being drained
    assign out_load = (r_state == ST_DONE) && (!r_o_valid || !i_stall);

    // disturb target: center, east, west, south, north
    always_comb begin
        d_row = r_row;
        d_col = r_col;
        case (r_k)
            3'd1:    d_col = r_col + 1'b1;
            3'd2:    d_col = r_col - 1'b1;
            3'd3:    d_row = r_row + 1'b1;
            3'd4:    d_row = r_row - 1'b1;
            default: ;
        endcase
    end

    assign amt = (r_k == 3'd0) ? r_mag : (r_mag >>> 1);
    assign nsat = f_sat32(ACC_W'(r_nsum));

    // read and write addressing of the current and previous grids
    always_comb begin
        cur_ra  = {r_row, r_col};
        prv_ra  = {r_row, r_col};
        wr_en   = 1'b0;
        wr_cur  = 1'b0;
        wr_addr = {r_row, r_col};
        wr_data = mac_out;
        if (r_state == ST_DRD || r_state == ST_DWR) begin
            cur_ra  = {d_row, d_col};
            wr_addr = {d_row, d_col};
        end
        if (r_state == ST_SWEEP) begin
            case (r_ph)
                4'd0:    cur_ra = {r_row - 1'b1, r_col};
                4'd1:    cur_ra = {r_row + 1'b1, r_col};
                4'd2:    cur_ra = {r_row, r_col - 1'b1};
                4'd3:    cur_ra = {r_row, r_col + 1'b1};
                default: cur_ra = {r_row, r_col};
            endcase
        end
        if (r_state == ST_DWR) begin
            wr_en   = 1'b1;
            wr_cur  = 1'b1;
            wr_data = f_sat32(ACC_W'(cur_q) + ACC_W'(amt));
        end
        if (r_state == ST_SWEEP && r_ph == PH_LAST) begin
            wr_en = 1'b1;
        end
    end

    // map current/previous onto the two RAMs; clearing writes both
    assign tgt_b = wr_cur ? r_cur_b : !r_cur_b;
    assign we_a  = (r_state == ST_CLEAR) || (wr_en && !tgt_b);
    assign we_b  = (r_state == ST_CLEAR) || (wr_en && tgt_b);
    assign wa    = (r_state == ST_CLEAR) ? r_clr_cnt : wr_addr;
    assign wd    = (r_state == ST_CLEAR) ? 32'd0 : wr_data;

    wgs_ram #(.DEPTH(GRID_DEPTH), .WIDTH(32)) u_grid_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (wa),
        .i_wdata (wd),
        .i_raddr (r_cur_b ? prv_ra : cur_ra),
        .o_rdata (q_a)
    );

    wgs_ram #(.DEPTH(GRID_DEPTH), .WIDTH(32)) u_grid_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (wa),
        .i_wdata (wd),
        .i_raddr (r_cur_b ? cur_ra : prv_ra),
        .o_rdata (q_b)
    );

    assign cur_q = r_cur_b ? q_b : q_a;
    assign prv_q = r_cur_b ? q_a : q_b;

    // multiplier schedule: k1*prev, k2*curr, k3*neighbor sum
    always_comb begin
        mac_ctl  = '0;
        mac_coef = r_k1;
        mac_val  = r_pval;
        if (r_state == ST_SWEEP) begin
            mac_ctl.clr = (r_ph == 4'd0);
            mac_ctl.mul = (r_ph == 4'd5) || (r_ph == 4'd6) || (r_ph == 4'd7);
            mac_ctl.acc = (r_ph == 4'd6) || (r_ph == 4'd7) || (r_ph == 4'd8);
        end
        case (r_ph)
            4'd6: begin
                mac_coef = r_k2;
                mac_val  = r_cval;
            end
            4'd7: begin
                mac_coef = r_k3;
                mac_val  = nsat;
            end
            default: ;
        endcase
    end

    wgs_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_coef (mac_coef),
        .i_val  (mac_val),
        .o_sat  (mac_out)
    );

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_comb begin
        unique case (cfg_idx)
            REG_NUM_ROWS:  prdata = {25'd0, r_num_rows};
            REG_NUM_COLS:  prdata = {25'd0, r_num_cols};
            REG_COEF_PREV: prdata = r_k1;
            REG_COEF_CURR: prdata = r_k2;
            REG_COEF_NBR:  prdata = r_k3;
            REG_STEP_PER:  prdata = r_step_per;
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= ROWS_LIM;
            r_num_cols <= COLS_LIM;
            r_k1       <= '0;
            r_k2       <= '0;
            r_k3       <= '0;
            r_step_per <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_idx)
                REG_NUM_ROWS:  r_num_rows <= pwdata[6:0];
                REG_NUM_COLS:  r_num_cols <= pwdata[6:0];
                REG_COEF_PREV: r_k1       <= pwdata;
                REG_COEF_CURR: r_k2       <= pwdata;
                REG_COEF_NBR:  r_k3       <= pwdata;
                REG_STEP_PER:  r_step_per <= pwdata;
                default:       ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_cur_b   <= 1'b0;
            r_accum   <= '0;
            r_o_valid <= 1'b0;
            r_ph      <= '0;
            r_k       <= '0;
        end else begin
            // load or drain the output register
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (&r_clr_cnt) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_res_h <= '0;
                        r_res_s <= step_go && !sweep_go;
                        r_res_e <= (i_func == FUNC_DISTURB && !disturb_ok)
                                   || (i_func == FUNC_READ && !read_ok);
                        r_row   <= sweep_go ? ROW_W'(1) : i_row;
                        r_col   <= sweep_go ? COL_W'(1) : i_col;
                        r_mag   <= i_magnitude;
                        r_k     <= '0;
                        r_ph    <= '0;
                        case (i_func)
                            FUNC_TICK: begin
                                // no interior: swap only and clear the accumulator
                                r_accum <= (step_go && !sweep_go) ? 32'd0 : tacc;
                                if (step_go && !sweep_go) begin
                                    r_cur_b <= !r_cur_b;
                                end
                                r_state <= sweep_go ? ST_SWEEP : ST_DONE;
                            end
                            FUNC_DISTURB: r_state <= disturb_ok ? ST_DRD : ST_DONE;
                            FUNC_READ:    r_state <= read_ok ? ST_RD : ST_DONE;
                            default:      r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_RD: begin
                    r_state <= ST_RQ;
                end
                ST_RQ: begin
                    r_res_h <= cur_q;
                    r_state <= ST_DONE;
                end
                ST_DRD: begin
                    r_state <= ST_DWR;
                end
                ST_DWR: begin
                    if (r_k == 3'd4) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_DRD;
                    end
                end
                ST_SWEEP: begin
                    r_ph <= (r_ph == PH_LAST) ? 4'd0 : r_ph + 1'b1;
                    case (r_ph)
                        4'd1: begin
                            r_nsum <= 34'(cur_q);
                            r_pval <= prv_q;
                        end
                        4'd2, 4'd3, 4'd4: r_nsum <= r_nsum + 34'(cur_q);
                        4'd5: r_cval <= cur_q;
                        PH_LAST: begin
                            // advance to the next interior point
                            if (({1'b0, r_col} + 7'd2) < cols_u) begin
                                r_col <= r_col + 1'b1;
                            end else begin
                                r_col <= COL_W'(1);
                                if (({1'b0, r_row} + 7'd2) < rows_u) begin
                                    r_row <= r_row + 1'b1;
                                end else begin
                                    r_cur_b <= !r_cur_b;
                                    r_accum <= '0;
                                    r_res_s <= 1'b1;
                                    r_state <= ST_DONE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_height  <= r_res_h;
            r_o_stepped <= r_res_s;
            r_o_error   <= r_res_e;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_height  = r_o_height;
    assign o_stepped = r_o_stepped;
    assign o_error   = r_o_error;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("block took a word without going busy");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we_a || we_b) |-> (r_state == ST_CLEAR || r_state == ST_DWR
                            || r_state == ST_SWEEP))
        else $error("grid write outside clear, disturb or sweep");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph <= PH_LAST)
        else $error("sweep phase out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_height) && $stable(o_stepped)
                                  && $stable(o_error)))
        else $error("result word changed while stalled");

    a_sweep_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_row != '0 && r_col != '0))
        else $error("sweep reached a boundary point");

endmodule

### dv/wgs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgs_checker
// Watches the word channels and the register port of the wave grid block,
// predicts every result word from its own copy of the grids and registers,
// and compares each delivered word against the oldest prediction.
// ----------------------------------------------------------------------------
module wgs_checker
    import wgs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            func,
    input  logic [31:0]           elapsed,
    input  logic [5:0]            row,
    input  logic [5:0]            col,
    input  logic signed [31:0]    magnitude,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic signed [31:0]    height,
    input  logic                  stepped,
    input  logic                  error,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    output int                    pending,
    output int                    mismatches
);

    typedef struct {
        logic signed [31:0] height;
        logic               stepped;
        logic               error;
    } wave_result_t;

    wave_result_t result_q[$];

    logic signed [31:0] heights [2][GRID_DEPTH];
    bit                 cur_sel;
    logic [31:0]        time_acc;
    logic [6:0]         rows_reg, cols_reg;
    logic signed [31:0] k_prev, k_curr, k_nbr;
    logic [31:0]        period;

    assign pending = result_q.size();

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Q16.16 product, rounded half up
    function automatic longint round_mul(longint k, longint x);
        return (k * x + 64'sd32768) >>> 16;
    endfunction

    function automatic int eff_rows();
        return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function automatic int eff_cols();
        return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    function automatic void advance_grid();
        int     nr, nc, p;
        longint nsum, v;
        bit     cs, ps;
        nr = eff_rows();
        nc = eff_cols();
        cs = cur_sel;
        ps = !cur_sel;
        for (int r = 1; r + 1 < nr; r++) begin
            for (int c = 1; c + 1 < nc; c++) begin
                p = r * MAX_COLS + c;
                nsum = longint'(heights[cs][p + MAX_COLS]) + heights[cs][p - MAX_COLS]
                     + heights[cs][p + 1] + heights[cs][p - 1];
                v = round_mul(k_prev, heights[ps][p]) + round_mul(k_curr, heights[cs][p])
                  + round_mul(k_nbr, clamp32(nsum));
                heights[ps][p] = clamp32(v);
            end
        end
        cur_sel  = !cur_sel;
        time_acc = '0;
    endfunction

    function automatic void bump(int p, longint amount);
        heights[cur_sel][p] = clamp32(longint'(heights[cur_sel][p]) + amount);
    endfunction

    function automatic wave_result_t predict_word();
        wave_result_t res;
        logic [32:0]  sum;
        int           p, nr, nc;
        longint       mag, half;
        res = '{height: '0, stepped: 1'b0, error: 1'b0};
        nr  = eff_rows();
        nc  = eff_cols();
        case (func)
            FUNC_TICK: begin
                sum = {1'b0, time_acc} + {1'b0, elapsed};
                time_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                if (time_acc >= period) begin
                    advance_grid();
                    res.stepped = 1'b1;
                end
            end
            FUNC_DISTURB: begin
                if (row >= 2 && int'(row) + 2 < nr && col >= 2 && int'(col) + 2 < nc) begin
                    p    = row * MAX_COLS + col;
                    mag  = magnitude;
                    half = mag >>> 1;
                    bump(p, mag);
                    bump(p + 1, half);
                    bump(p - 1, half);
                    bump(p + MAX_COLS, half);
                    bump(p - MAX_COLS, half);
                end else begin
                    res.error = 1'b1;
                end
            end
            FUNC_READ: begin
                if (int'(row) < nr && int'(col) < nc) res.height = heights[cur_sel][row * MAX_COLS + col];
                else res.error = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk) begin
        wave_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < GRID_DEPTH; i++) begin
                heights[0][i] = '0;
                heights[1][i] = '0;
            end
            cur_sel    = 1'b0;
            time_acc   = '0;
            rows_reg   = 7'd64;
            cols_reg   = 7'd64;
            k_prev     = '0;
            k_curr     = '0;
            k_nbr      = '0;
            period     = '0;
            mismatches = 0;
            result_q.delete();
        end else begin
            // compare the delivered word first; it is always older than any new input
            if (out_valid && !out_stall) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result word: height=%h stepped=%b error=%b",
                           height, stepped, error);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    if (height !== want.height) begin
                        $error("height: expected %h, actual %h", want.height, height);
                        mismatches++;
                    end
                    if (stepped !== want.stepped) begin
                        $error("stepped: expected %b, actual %b", want.stepped, stepped);
                        mismatches++;
                    end
                    if (error !== want.error) begin
                        $error("error: expected %b, actual %b", want.error, error);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall) result_q.push_back(predict_word());
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_NUM_ROWS:  rows_reg = pwdata[6:0];
                    REG_NUM_COLS:  cols_reg = pwdata[6:0];
                    REG_COEF_PREV: k_prev   = pwdata;
                    REG_COEF_CURR: k_curr   = pwdata;
                    REG_COEF_NBR:  k_nbr    = pwdata;
                    REG_STEP_PER:  period   = pwdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

### dv/wave_grid_stencil_step_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave_grid_stencil_step_test
// Drives ticks, disturbs and reads into the wave grid block under several
// register settings, with bursty input and a patterned output stall; the
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module wave_grid_stencil_step_test;
    import wgs_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_func = '0;
    logic [31:0]        i_elapsed = '0;
    logic [5:0]         i_row = '0;
    logic [5:0]         i_col = '0;
    logic signed [31:0] i_magnitude = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic signed [31:0] o_height;
    logic               o_stepped;
    logic               o_error;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int  words_pending;
    int  mismatches;
    int  cycles;
    int  burst_left;
    bit  long_hold_req;
    // current grid size as the stimulus sees it, for aiming disturbs and reads
    int  rows_now;
    int  cols_now;

    wave_grid_stencil_step dut (.*);

    wgs_checker u_checker (
        .clk(i_clk), .rst_n(i_rst_n),
        .in_valid(i_valid), .in_stall(o_stall), .func(i_func), .elapsed(i_elapsed),
        .row(i_row), .col(i_col), .magnitude(i_magnitude),
        .out_valid(o_valid), .out_stall(i_stall), .height(o_height),
        .stepped(o_stepped), .error(o_error),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .pending(words_pending), .mismatches(mismatches)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: the largest step sweeps 62x62 points, so the limit leaves
    // room for many full sweeps plus the clearing pass.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver stall: switch among four patterns picked at random; once, hold off for a
    // long stretch so the output register fills and the input backs up.
    initial begin
        int mode;
        int hold;
        bit held;
        mode = 0;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !held) begin
                hold = 0;
                i_stall <= 1'b1;
                while (hold < 300) begin
                    @(negedge i_clk);
                    hold++;
                end
                held = 1'b1;
            end
            if (cycles % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= (cycles % 8) < 3;
            endcase
        end
    end

    // Register write: setup cycle, then access cycle. Enter and leave at a falling edge.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_NUM_ROWS) rows_now = (value[6:0] > 64) ? 64 : value[6:0];
        if (idx == REG_NUM_COLS) cols_now = (value[6:0] > 64) ? 64 : value[6:0];
    endtask

    // Drain every outstanding word, then let the block settle before reconfiguring.
    task automatic drain();
        i_valid <= 1'b0;
        while (words_pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic configure(logic [6:0] nr, logic [6:0] nc, logic [31:0] kp,
                             logic [31:0] kc, logic [31:0] kn, logic [31:0] per);
        drain();
        write_reg(REG_NUM_ROWS, {25'h0, nr});
        write_reg(REG_NUM_COLS, {25'h0, nc});
        write_reg(REG_COEF_PREV, kp);
        write_reg(REG_COEF_CURR, kc);
        write_reg(REG_COEF_NBR, kn);
        write_reg(REG_STEP_PER, per);
    endtask

    // Offer one word; bursts of random length with random gaps between.
    // Enter and leave at a falling edge; valid stays high into the next word.
    task automatic send_word(logic [1:0] f, logic [31:0] el, logic [5:0] r,
                             logic [5:0] c, logic [31:0] mag);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_func      <= f;
        i_elapsed   <= el;
        i_row       <= r;
        i_col       <= c;
        i_magnitude <= mag;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic random_word(int tick_pct);
        int          pick;
        logic [5:0]  r, c;
        logic [31:0] el, mag;
        pick = $urandom_range(0, 99);
        r = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, rows_now));
        c = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, cols_now));
        el  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0002_0000);
        mag = ($urandom_range(0, 3) == 0) ? $urandom
                                          : $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
        if (pick < tick_pct) send_word(FUNC_TICK, el, r, c, mag);
        else if (pick < tick_pct + 30) send_word(FUNC_DISTURB, el, r, c, mag);
        else if (pick < 97) send_word(FUNC_READ, el, r, c, mag);
        else send_word(2'd3, $urandom, 6'($urandom), 6'($urandom), $urandom);
    endtask

    initial begin
        int kc;
        burst_left    = 0;
        long_hold_req = 1'b0;
        rows_now      = 64;
        cols_now      = 64;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset settings, zero period so a tick sweeps the full grid.
        send_word(FUNC_READ, '0, 6'd0, 6'd0, '0);
        send_word(FUNC_READ, '0, 6'd63, 6'd63, '0);
        send_word(FUNC_TICK, '0, '0, '0, '0);

        configure(7'd6, 7'd7, 32'hFFFF_0000, 32'h0001_8000, 32'h0000_2000, 32'h0001_0000);
        send_word(FUNC_DISTURB, '0, 6'd2, 6'd2, 32'h7FFF_FFFF);
        send_word(FUNC_DISTURB, '0, 6'd2, 6'd2, 32'h7FFF_FFFF);   // saturates up
        send_word(FUNC_DISTURB, '0, 6'd3, 6'd4, 32'h8000_0000);   // drives the center to the lower limit
        send_word(FUNC_DISTURB, '0, 6'd1, 6'd2, 32'h0001_0000);   // too near the edge
        send_word(FUNC_DISTURB, '0, 6'd2, 6'd5, 32'h0001_0000);
        send_word(FUNC_DISTURB, '0, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_word(FUNC_READ, '0, 6'd5, 6'd6, '0);
        send_word(FUNC_READ, '0, 6'd6, 6'd0, '0);                 // outside the grid
        send_word(FUNC_READ, '0, 6'd0, 6'd7, '0);
        send_word(2'd3, 32'hFFFF_FFFF, 6'h3F, 6'h3F, 32'hFFFF_FFFF);
        send_word(FUNC_TICK, 32'h0000_8000, '0, '0, '0);          // short of the period
        send_word(FUNC_TICK, 32'h0000_8000, '0, '0, '0);          // reaches it
        send_word(FUNC_TICK, 32'hFFFF_FFFF, '0, '0, '0);
        send_word(FUNC_READ, '0, 6'd2, 6'd2, '0);
        send_word(FUNC_READ, '0, 6'd3, 6'd3, '0);

        // One interior row; accumulator pinned at its ceiling against the longest period.
        configure(7'd3, 7'd4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(FUNC_TICK, 32'hFFFF_FFFF, '0, '0, '0);
        send_word(FUNC_TICK, 32'hFFFF_0000, '0, '0, '0);
        send_word(FUNC_TICK, 32'hFFFF_0000, '0, '0, '0);
        send_word(FUNC_READ, '0, 6'd2, 6'd3, '0);

        // Size above the maximum clamps; extreme coefficients on saturated heights.
        configure(7'd127, 7'd127, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_word(FUNC_READ, '0, 6'd63, 6'd63, '0);
        send_word(FUNC_DISTURB, '0, 6'd61, 6'd61, 32'h4000_0000);
        send_word(FUNC_TICK, '0, '0, '0, '0);
        send_word(FUNC_READ, '0, 6'd2, 6'd2, '0);

        // Random phases, mostly small grids so sweeps stay short.
        for (int ph = 0; ph < 5; ph++) begin
            kc = $urandom_range(0, 32'h0000_4000);
            if (ph == 3)
                configure(7'd5, 7'd5, $urandom, $urandom, $urandom, $urandom_range(0, 32'h8000));
            else
                configure(7'($urandom_range(5, (ph == 1) ? 20 : 12)),
                          7'($urandom_range(5, (ph == 1) ? 20 : 12)),
                          32'hFFFF_0000 + $urandom_range(0, 32'h200),
                          32'h0002_0000 - 4 * kc, kc,
                          $urandom_range(0, 32'h0004_0000));
            if (ph == 2) long_hold_req = 1'b1;
            repeat (23) random_word((ph == 3) ? 40 : 25);
        end

        drain();
        repeat (40) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/wgs_pkg.sv
rtl/core/wgs_ram.sv
rtl/core/wgs_mac.sv
rtl/core/wave_grid_stencil_step.sv
dv/wgs_checker.sv
dv/wave_grid_stencil_step_test.sv
